// File: hdl/brss_pkg.sv
// ----------------------------------------------------------------------------
// brss_pkg: shared constants for the banked request service scheduler
// Field widths, register indexes and port limits used by the channel
// interfaces and the scheduler core.
// ----------------------------------------------------------------------------
package brss_pkg;

   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 13;
   localparam int TICK_W      = 64;
   localparam int LAT_W       = 32;
   localparam int TPB_W       = 16;
   localparam int DEPTH_W     = 9;
   localparam int STRIDE_W    = 13;
   localparam int PCNT_W      = 4;
   localparam int SEQ_W       = 32;
   localparam int CAUSE_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   localparam int MAX_PORTS   = 8;
   localparam int PORT_W      = 3;
   localparam int MAX_REQ_BYTES = 4096;

   // chunk duration: chunk bytes times Q8 rate, fraction dropped
   localparam int PROD_W      = SIZE_W + TPB_W;
   localparam int DUR_W       = PROD_W - 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TPB     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PORTS   = 3'd5;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_RETRY = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_FULL  = 2'd2;

endpackage

// File: hdl/brss_req_if.sv
// ----------------------------------------------------------------------------
// brss_req_if: request channel
// Carries new requests and completion events into the scheduler.
// ----------------------------------------------------------------------------
interface brss_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [brss_pkg::ADDR_W-1:0]   req_address;
   logic [brss_pkg::SIZE_W-1:0]   req_size;
   logic [brss_pkg::TICK_W-1:0]   req_avail_tick;

   modport source (output valid, func, req_address, req_size, req_avail_tick, input ready);
   modport sink   (input valid, func, req_address, req_size, req_avail_tick, output ready);
endinterface

// File: hdl/brss_rsp_if.sv
// ----------------------------------------------------------------------------
// brss_rsp_if: result channel
// Carries one scheduling or admission result per transaction.
// ----------------------------------------------------------------------------
interface brss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [brss_pkg::CAUSE_W-1:0]  refuse_cause;
   logic [brss_pkg::TICK_W-1:0]   svc_start_tick;
   logic [brss_pkg::TICK_W-1:0]   resp_due_tick;
   logic [brss_pkg::SEQ_W-1:0]    sequence_number;
   logic [brss_pkg::DEPTH_W-1:0]  inflight_now;
   logic                          retry_grant;
   logic [brss_pkg::SEQ_W-1:0]    full_retry_total;
   logic [brss_pkg::DEPTH_W-1:0]  peak_inflight;

   modport source (output valid, accepted, refuse_cause, svc_start_tick, resp_due_tick,
                   sequence_number, inflight_now, retry_grant, full_retry_total,
                   peak_inflight, input ready);
   modport sink   (input valid, accepted, refuse_cause, svc_start_tick, resp_due_tick,
                   sequence_number, inflight_now, retry_grant, full_retry_total,
                   peak_inflight, output ready);
endinterface

// File: hdl/brss_csr_if.sv
// ----------------------------------------------------------------------------
// brss_csr_if: configuration write channel
// Register index and write data for the scheduler's settings.
// ----------------------------------------------------------------------------
interface brss_csr_if;
   logic                             valid;
   logic                             ready;
   logic [brss_pkg::CSR_IDX_W-1:0]   index;
   logic [brss_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/banked_request_service_scheduler.sv
// ----------------------------------------------------------------------------
// banked_request_service_scheduler
// Admission control and interleaved port scheduling for memory requests.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A completion or a refused request
// passes through the IDLE, ADMIT and FIN states; its result is written to
// the output register from FIN. An admitted request passes through IDLE and
// ADMIT, then CHK, RD and UPD per stride chunk and DIV per offset division,
// and ends in FIN. A division runs for a chunk at or above base_address that
// does not start on the boundary left by the previous chunk: the first such
// chunk of the request, and one more each time the chunk cursor crosses up
// into the address range from below base_address or wraps at 48 bits. The
// division is a bit-serial restoring divider that also reduces the quotient
// modulo the port count; each chunk does a read, update and write back of its
// port's free tick in an 8-entry memory. The result sits in an output
// register, so the next transaction is accepted while it waits to be taken;
// that next transaction holds in its last cycle until the earlier result has
// been taken.
// ----------------------------------------------------------------------------
module banked_request_service_scheduler (
   input logic        clock,
   input logic        reset,
   brss_req_if.sink   req_ch,
   brss_rsp_if.source rsp_ch,
   brss_csr_if.sink   csr_ch
);
   import brss_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADMIT = 3'd1;
   localparam logic [2:0] ST_CHK   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_UPD   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // configuration
   logic [ADDR_W-1:0]   base_ff;
   logic [LAT_W-1:0]    latency_ff;
   logic [TPB_W-1:0]    tpb_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [PCNT_W-1:0]   pcnt_ff;

   // block state
   logic [2:0]          state_ff, state_in;
   logic [DEPTH_W-1:0]  inflight_ff, inflight_in;
   logic                retry_ff, retry_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [SEQ_W-1:0]    full_cnt_ff, full_cnt_in;
   logic [DEPTH_W-1:0]  peak_ff, peak_in;
   logic [MAX_PORTS-1:0] pvalid_ff, pvalid_in;

   // transaction working registers
   logic                func_ff, func_in;
   logic [ADDR_W-1:0]   cur_ff, cur_in;
   logic [SIZE_W-1:0]   left_ff, left_in;
   logic [TICK_W-1:0]   ready_ff, ready_in;
   logic [TICK_W-1:0]   svc_ff, svc_in;
   logic [CAUSE_W-1:0]  cause_ff, cause_in;
   logic                need_div_ff, need_div_in;
   logic                below_ff, below_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic [SIZE_W-1:0]   chunk_ff, chunk_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic [ADDR_W-1:0]   dvd_ff, dvd_in;
   logic [5:0]          dcnt_ff, dcnt_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   logic                o_acc_ff, o_acc_in;
   logic [CAUSE_W-1:0]  o_cause_ff, o_cause_in;
   logic [TICK_W-1:0]   o_svc_ff, o_svc_in;
   logic [TICK_W-1:0]   o_rsp_ff, o_rsp_in;
   logic [SEQ_W-1:0]    o_seq_ff, o_seq_in;
   logic [DEPTH_W-1:0]  o_infl_ff, o_infl_in;
   logic                o_grant_ff, o_grant_in;

   // port free tick memory
   logic [TICK_W-1:0]   free_mem [MAX_PORTS];
   logic [TICK_W-1:0]   rd_data_ff;
   logic                rd_valid_ff;
   logic                mem_we;
   logic [TICK_W-1:0]   mem_wdata;

   // derived values
   logic [STRIDE_W-1:0] eff_stride;
   logic [PCNT_W-1:0]   eff_ports;
   logic                out_free;
   logic                req_fire;
   logic [STRIDE_W:0]   div_r2;
   logic                div_ge;
   logic [PCNT_W-1:0]   div_m2;
   logic [STRIDE_W-1:0] room;
   logic [SIZE_W-1:0]   chunk_sel;
   logic [PROD_W-1:0]   prod;
   logic [TICK_W-1:0]   free_now;
   logic [TICK_W-1:0]   start_tick;
   logic [ADDR_W:0]     cur_sum;
   logic [PCNT_W-1:0]   port_next;
   logic [DEPTH_W-1:0]  dec_cnt;
   logic [DEPTH_W-1:0]  inc_cnt;

   assign eff_stride = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
   assign eff_ports  = (pcnt_ff == '0) ? PCNT_W'(1)
                     : (pcnt_ff > PCNT_W'(MAX_PORTS)) ? PCNT_W'(MAX_PORTS) : pcnt_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.accepted         = o_acc_ff;
   assign rsp_ch.refuse_cause     = o_cause_ff;
   assign rsp_ch.svc_start_tick   = o_svc_ff;
   assign rsp_ch.resp_due_tick    = o_rsp_ff;
   assign rsp_ch.sequence_number  = o_seq_ff;
   assign rsp_ch.inflight_now     = o_infl_ff;
   assign rsp_ch.retry_grant      = o_grant_ff;
   assign rsp_ch.full_retry_total = full_cnt_ff;
   assign rsp_ch.peak_inflight    = peak_ff;

   // one restoring-division step, quotient reduced modulo the port count
   assign div_r2 = {rem_ff, dvd_ff[ADDR_W-1]};
   assign div_ge = div_r2 >= {1'b0, eff_stride};
   assign div_m2 = {port_ff, div_ge};

   assign room      = eff_stride - rem_ff;
   assign chunk_sel = (left_ff < room) ? left_ff : room;
   assign prod      = PROD_W'(chunk_sel) * PROD_W'(tpb_ff);

   assign free_now   = rd_valid_ff ? rd_data_ff : '0;
   assign start_tick = (free_now > ready_ff) ? free_now : ready_ff;
   assign cur_sum    = {1'b0, cur_ff} + (ADDR_W+1)'(chunk_ff);
   assign port_next  = {1'b0, port_ff} + PCNT_W'(1);

   assign dec_cnt = (inflight_ff == '0) ? '0 : inflight_ff - DEPTH_W'(1);
   assign inc_cnt = inflight_ff + DEPTH_W'(1);

   assign mem_we    = (state_ff == ST_UPD);
   assign mem_wdata = start_tick + TICK_W'(dur_ff);

   always_comb begin
      state_in     = state_ff;
      inflight_in  = inflight_ff;
      retry_in     = retry_ff;
      seq_in       = seq_ff;
      full_cnt_in  = full_cnt_ff;
      peak_in      = peak_ff;
      pvalid_in    = pvalid_ff;
      func_in      = func_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      ready_in     = ready_ff;
      svc_in       = svc_ff;
      cause_in     = cause_ff;
      need_div_in  = need_div_ff;
      below_in     = below_ff;
      rem_in       = rem_ff;
      port_in      = port_ff;
      chunk_in     = chunk_ff;
      dur_in       = dur_ff;
      dvd_in       = dvd_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      o_acc_in     = o_acc_ff;
      o_cause_in   = o_cause_ff;
      o_svc_in     = o_svc_ff;
      o_rsp_in     = o_rsp_ff;
      o_seq_in     = o_seq_ff;
      o_infl_in    = o_infl_ff;
      o_grant_in   = o_grant_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_ch.func;
               cur_in   = req_ch.req_address;
               left_in  = (req_ch.req_size > SIZE_W'(MAX_REQ_BYTES))
                        ? SIZE_W'(MAX_REQ_BYTES) : req_ch.req_size;
               ready_in = req_ch.req_avail_tick;
               state_in = ST_ADMIT;
            end
         end
         ST_ADMIT: begin
            svc_in      = ready_ff;
            need_div_in = 1'b1;
            priority if (func_ff) begin
               cause_in = CAUSE_NONE;
               state_in = ST_FIN;
            end else if (retry_ff) begin
               cause_in = CAUSE_RETRY;
               state_in = ST_FIN;
            end else if (inflight_ff >= depth_ff) begin
               cause_in = CAUSE_FULL;
               state_in = ST_FIN;
            end else begin
               cause_in = CAUSE_NONE;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            priority if (left_ff == '0) begin
               state_in = ST_FIN;
            end else if (cur_ff < base_ff) begin
               // below the range: offset zero, port zero
               below_in = 1'b1;
               rem_in   = '0;
               port_in  = '0;
               state_in = ST_RD;
            end else if (need_div_ff) begin
               below_in = 1'b0;
               dvd_in   = cur_ff - base_ff;
               rem_in   = '0;
               port_in  = '0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end else begin
               below_in = 1'b0;
               state_in = ST_RD;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? STRIDE_W'(div_r2 - {1'b0, eff_stride}) : STRIDE_W'(div_r2);
            port_in = (div_m2 >= eff_ports) ? PORT_W'(div_m2 - eff_ports) : PORT_W'(div_m2);
            dvd_in  = {dvd_ff[ADDR_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'(ADDR_W - 1)) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            chunk_in = chunk_sel;
            dur_in   = prod[PROD_W-1:8];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            pvalid_in[port_ff] = 1'b1;
            if (start_tick > svc_ff) begin
               svc_in = start_tick;
            end
            cur_in  = cur_sum[ADDR_W-1:0];
            left_in = left_ff - chunk_ff;
            if (below_ff || cur_sum[ADDR_W]) begin
               need_div_in = 1'b1;
            end else begin
               // continue on the next stride boundary
               need_div_in = 1'b0;
               rem_in      = '0;
               port_in     = (port_next == eff_ports) ? '0 : port_next[PORT_W-1:0];
            end
            state_in = ST_CHK;
         end
         ST_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               o_cause_in   = cause_ff;
               o_acc_in     = 1'b0;
               o_svc_in     = '0;
               o_rsp_in     = '0;
               o_seq_in     = '0;
               o_grant_in   = 1'b0;
               o_infl_in    = inflight_ff;
               if (func_ff) begin
                  inflight_in = dec_cnt;
                  o_infl_in   = dec_cnt;
                  if (retry_ff && (dec_cnt < depth_ff)) begin
                     retry_in   = 1'b0;
                     o_grant_in = 1'b1;
                  end
               end else if (cause_ff == CAUSE_FULL) begin
                  retry_in    = 1'b1;
                  full_cnt_in = full_cnt_ff + SEQ_W'(1);
               end else if (cause_ff == CAUSE_NONE) begin
                  o_acc_in    = 1'b1;
                  o_svc_in    = svc_ff;
                  o_rsp_in    = svc_ff + TICK_W'(latency_ff);
                  o_seq_in    = seq_ff;
                  seq_in      = seq_ff + SEQ_W'(1);
                  inflight_in = inc_cnt;
                  o_infl_in   = inc_cnt;
                  if (inc_cnt > peak_ff) begin
                     peak_in = inc_cnt;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inflight_ff  <= '0;
         retry_ff     <= 1'b0;
         seq_ff       <= '0;
         full_cnt_ff  <= '0;
         peak_ff      <= '0;
         pvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inflight_ff  <= inflight_in;
         retry_ff     <= retry_in;
         seq_ff       <= seq_in;
         full_cnt_ff  <= full_cnt_in;
         peak_ff      <= peak_in;
         pvalid_ff    <= pvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      ready_ff    <= ready_in;
      svc_ff      <= svc_in;
      cause_ff    <= cause_in;
      need_div_ff <= need_div_in;
      below_ff    <= below_in;
      rem_ff      <= rem_in;
      port_ff     <= port_in;
      chunk_ff    <= chunk_in;
      dur_ff      <= dur_in;
      dvd_ff      <= dvd_in;
      dcnt_ff     <= dcnt_in;
      o_acc_ff    <= o_acc_in;
      o_cause_ff  <= o_cause_in;
      o_svc_ff    <= o_svc_in;
      o_rsp_ff    <= o_rsp_in;
      o_seq_ff    <= o_seq_in;
      o_infl_ff   <= o_infl_in;
      o_grant_ff  <= o_grant_in;
   end

   // free tick memory: read in RD, write back in UPD
   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_mem[port_ff] <= mem_wdata;
      end
      rd_data_ff  <= free_mem[port_ff];
      rd_valid_ff <= pvalid_ff[port_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         latency_ff <= '0;
         tpb_ff     <= TPB_W'(256);
         depth_ff   <= DEPTH_W'(4);
         stride_ff  <= STRIDE_W'(64);
         pcnt_ff    <= PCNT_W'(1);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_BASE:    base_ff    <= csr_ch.data[ADDR_W-1:0];
            CSR_LATENCY: latency_ff <= csr_ch.data[LAT_W-1:0];
            CSR_TPB:     tpb_ff     <= csr_ch.data[TPB_W-1:0];
            CSR_DEPTH:   depth_ff   <= csr_ch.data[DEPTH_W-1:0];
            CSR_STRIDE:  stride_ff  <= csr_ch.data[STRIDE_W-1:0];
            CSR_PORTS:   pcnt_ff    <= csr_ch.data[PCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// File: sim/banked_request_service_scheduler_tb.sv
// ----------------------------------------------------------------------------
// banked_request_service_scheduler_tb: self-checking testbench
// Drives requests and completions through several register settings, predicts
// each admission result and port schedule, and compares every result
// transaction field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module banked_request_service_scheduler_tb;
   import brss_pkg::*;

   localparam int CYCLE_LIMIT = 100000000;
   localparam int EXP_DEPTH = 16;
   localparam bit [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      bit                func;
      bit [ADDR_W-1:0]   addr;
      bit [SIZE_W-1:0]   size;
      bit [TICK_W-1:0]   tick;
   } req_item_type;

   typedef struct packed {
      bit                accepted;
      bit [CAUSE_W-1:0]  cause;
      bit [TICK_W-1:0]   svc_tick;
      bit [TICK_W-1:0]   rsp_tick;
      bit [SEQ_W-1:0]    seq;
      bit [DEPTH_W-1:0]  inflight;
      bit                grant;
      bit [SEQ_W-1:0]    full_total;
      bit [DEPTH_W-1:0]  peak;
   } sched_result_type;

   class sched_scoreboard;
      bit [ADDR_W-1:0]   base_addr;
      bit [LAT_W-1:0]    latency;
      bit [TPB_W-1:0]    tpb;
      bit [DEPTH_W-1:0]  depth;
      bit [STRIDE_W-1:0] stride;
      bit [PCNT_W-1:0]   nports;
      bit [63:0]         port_free [MAX_PORTS];
      bit [DEPTH_W-1:0]  inflight;
      bit                retry_pend;
      bit [SEQ_W-1:0]    seq_ctr;
      bit [SEQ_W-1:0]    full_ctr;
      bit [DEPTH_W-1:0]  peak;
      sched_result_type  exp_buf [EXP_DEPTH];
      int                exp_wr;
      int                exp_rd;
      int                exp_count;
      int                errors;

      function new();
         base_addr = '0; latency = '0; tpb = 16'd256; depth = 9'd4;
         stride = 13'd64; nports = 4'd1;
         foreach (port_free[i]) port_free[i] = '0;
         inflight = '0; retry_pend = 0; seq_ctr = '0; full_ctr = '0; peak = '0;
         exp_wr = 0; exp_rd = 0; exp_count = 0;
         errors = 0;
      endfunction

      function int outstanding();
         return exp_count;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] val);
         unique case (idx)
            CSR_BASE:    base_addr = val[ADDR_W-1:0];
            CSR_LATENCY: latency   = val[LAT_W-1:0];
            CSR_TPB:     tpb       = val[TPB_W-1:0];
            CSR_DEPTH:   depth     = val[DEPTH_W-1:0];
            CSR_STRIDE:  stride    = val[STRIDE_W-1:0];
            CSR_PORTS:   nports    = val[PCNT_W-1:0];
            default: ;
         endcase
      endfunction

      // walk the stride chunks, reserving each port; return latest start
      function bit [63:0] place_chunks(bit [63:0] addr, bit [63:0] size, bit [63:0] rdy);
         bit [63:0] strd, np, svc, cur, left, off, room, chunk, p, start;
         bit [PORT_W-1:0] pi;
         strd = (stride == 0) ? 64'd1 : 64'(stride);
         np = (nports == 0) ? 64'd1 : (nports > MAX_PORTS) ? 64'(MAX_PORTS) : 64'(nports);
         svc = rdy;
         cur = addr & ADDR_MASK;
         left = (size > MAX_REQ_BYTES) ? 64'(MAX_REQ_BYTES) : size;
         while (left != 0) begin
            off = (cur < 64'(base_addr)) ? 64'd0 : cur - 64'(base_addr);
            room = strd - (off % strd);
            chunk = (left < room) ? left : room;
            p = (off / strd) % np;
            pi = PORT_W'(p);
            start = (port_free[pi] > rdy) ? port_free[pi] : rdy;
            port_free[pi] = start + ((chunk * 64'(tpb)) >> 8);
            if (start > svc) svc = start;
            cur = (cur + chunk) & ADDR_MASK;
            left = left - chunk;
         end
         return svc;
      endfunction

      function void note_request(req_item_type it);
         sched_result_type r;
         r = '0;
         if (it.func) begin
            if (inflight > 0) inflight--;
            if (retry_pend && inflight < depth) begin
               retry_pend = 0;
               r.grant = 1;
            end
         end else if (retry_pend) begin
            r.cause = CAUSE_RETRY;
         end else if (inflight >= depth) begin
            r.cause = CAUSE_FULL;
            retry_pend = 1;
            full_ctr++;
         end else begin
            r.accepted = 1;
            r.svc_tick = place_chunks(64'(it.addr), 64'(it.size), it.tick);
            r.rsp_tick = r.svc_tick + 64'(latency);
            r.seq = seq_ctr;
            seq_ctr++;
            inflight++;
            if (inflight > peak) peak = inflight;
         end
         r.inflight = inflight;
         r.full_total = full_ctr;
         r.peak = peak;
         if (exp_count == EXP_DEPTH) begin
            $display("%0t: too many results outstanding", $time);
            errors++;
            return;
         end
         exp_buf[exp_wr] = r;
         exp_wr = (exp_wr + 1) % EXP_DEPTH;
         exp_count++;
      endfunction

      function void check_result(sched_result_type act);
         sched_result_type e;
         if (exp_count == 0) begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
            return;
         end
         e = exp_buf[exp_rd];
         exp_rd = (exp_rd + 1) % EXP_DEPTH;
         exp_count--;
         if (act !== e) begin
            errors++;
            $display("%0t: result mismatch", $time);
            $display("   expected acc=%0d cause=%0d svc=%h rsp=%h seq=%0d",
                     e.accepted, e.cause, e.svc_tick, e.rsp_tick, e.seq);
            $display("            infl=%0d grant=%0d full=%0d peak=%0d",
                     e.inflight, e.grant, e.full_total, e.peak);
            $display("   actual   acc=%0d cause=%0d svc=%h rsp=%h seq=%0d",
                     act.accepted, act.cause, act.svc_tick, act.rsp_tick, act.seq);
            $display("            infl=%0d grant=%0d full=%0d peak=%0d",
                     act.inflight, act.grant, act.full_total, act.peak);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   brss_req_if req_ch ();
   brss_rsp_if rsp_ch ();
   brss_csr_if csr_ch ();

   banked_request_service_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   sched_scoreboard sb = new();
   req_item_type    cur_item;
   int              req_taken = 0;
   int              csr_taken = 0;
   int              cycles = 0;
   bit              no_idle = 0;
   bit              quiet_stretch = 0;
   int              rsp_stall = 0;
   bit [63:0]       tick_base = 0;

   // sample both sides of every channel at the rising edge
   always @(posedge clock) begin : sample_blk
      sched_result_type act;
      cycles++;
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_request(cur_item);
         req_taken++;
      end
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         sb.write_reg(csr_ch.index, csr_ch.data);
         csr_taken++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act.accepted   = rsp_ch.accepted;
         act.cause      = rsp_ch.refuse_cause;
         act.svc_tick   = rsp_ch.svc_start_tick;
         act.rsp_tick   = rsp_ch.resp_due_tick;
         act.seq        = rsp_ch.sequence_number;
         act.inflight   = rsp_ch.inflight_now;
         act.grant      = rsp_ch.retry_grant;
         act.full_total = rsp_ch.full_retry_total;
         act.peak       = rsp_ch.peak_inflight;
         sb.check_result(act);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ch.ready = 0;
         rsp_stall--;
      end else begin
         rsp_ch.ready = 1;
         if (!no_idle && !quiet_stretch && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 15);
      end
   end

   task automatic send_item(req_item_type it);
      int target;
      if (!no_idle && !quiet_stretch && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      cur_item = it;
      req_ch.func = it.func;
      req_ch.req_address = it.addr;
      req_ch.req_size = it.size;
      req_ch.req_avail_tick = it.tick;
      req_ch.valid = 1;
      target = req_taken + 1;
      do @(negedge clock); while (req_taken < target);
   endtask

   task automatic drain();
      req_ch.valid = 0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] val);
      int target;
      target = csr_taken + 1;
      csr_ch.index = idx;
      csr_ch.data = val;
      csr_ch.valid = 1;
      do @(negedge clock); while (csr_taken < target);
      csr_ch.valid = 0;
   endtask

   task automatic program_all(bit [47:0] b, bit [31:0] l, bit [15:0] t,
                              bit [8:0] d, bit [12:0] s, bit [3:0] p);
      write_csr(CSR_BASE, b);
      write_csr(CSR_LATENCY, 48'(l));
      write_csr(CSR_TPB, 48'(t));
      write_csr(CSR_DEPTH, 48'(d));
      write_csr(CSR_STRIDE, 48'(s));
      write_csr(CSR_PORTS, 48'(p));
   endtask

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_item_type make_item(int done_pct, bit [12:0] size_cap);
      req_item_type it;
      int sel;
      it.func = ($urandom_range(0, 99) < done_pct);
      sel = $urandom_range(0, 99);
      if (sel < 50)
         it.addr = sb.base_addr + 48'($urandom_range(0, 20000));
      else if (sel < 65)
         it.addr = sb.base_addr - 48'($urandom_range(1, 300));
      else if (sel < 75)
         it.addr = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 300));
      else
         it.addr = ADDR_W'(rand64());
      sel = $urandom_range(0, 99);
      if (sel < 85)
         it.size = SIZE_W'($urandom_range(0, 200));
      else if (sel < 97)
         it.size = SIZE_W'($urandom_range(0, size_cap));
      else
         it.size = SIZE_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
         tick_base = tick_base + 64'($urandom_range(0, 100));
         it.tick = tick_base;
      end else if (sel < 90) begin
         it.tick = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
      end else begin
         it.tick = rand64();
      end
      return it;
   endfunction

   task automatic run_random(int n, int done_pct, bit [12:0] size_cap);
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
         send_item(make_item(done_pct, size_cap));
      end
   endtask

   initial begin
      req_item_type it;
      req_ch.valid = 0; req_ch.func = 0; req_ch.req_address = '0;
      req_ch.req_size = '0; req_ch.req_avail_tick = '0;
      csr_ch.valid = 0; csr_ch.index = CSR_BASE; csr_ch.data = '0;
      rsp_ch.ready = 0;
      repeat (4) @(negedge clock);
      reset = 0;

      // directed: reset settings, fill the pipeline and bounce off it
      it = '{func: 1, addr: '0, size: '0, tick: '0};
      send_item(it);
      it = '{func: 0, addr: 48'h0, size: 13'd1, tick: 64'd10};
      send_item(it);
      it = '{func: 0, addr: 48'd60, size: 13'd100, tick: 64'd5};
      send_item(it);
      it = '{func: 0, addr: 48'hFFFF_FFFF_FFF0, size: 13'd64, tick: '1};
      send_item(it);
      it = '{func: 0, addr: '1, size: 13'h1FFF, tick: 64'd0};
      send_item(it);
      it = '{func: 0, addr: 48'd7, size: 13'd0, tick: 64'd99};
      send_item(it);
      it.size = 13'd1;
      send_item(it);
      it = '{func: 1, addr: '1, size: '1, tick: '1};
      send_item(it);
      send_item(it);
      drain();

      // directed: addresses below base, many ports, near-maximum size and tick
      program_all(48'h1000, 32'd100, 16'd256, 9'd2, 13'd64, 4'd4);
      it = '{func: 0, addr: 48'h0F80, size: 13'd300, tick: 64'd0};
      send_item(it);
      it = '{func: 0, addr: 48'h0FFF, size: 13'd4096, tick: 64'hFFFF_FFFF_FFFF_FF00};
      send_item(it);
      it = '{func: 0, addr: 48'h1000, size: 13'd8, tick: 64'd1};
      send_item(it);
      it = '{func: 1, addr: '0, size: '0, tick: '0};
      send_item(it);
      send_item(it);
      send_item(it);
      run_random(300, 35, 13'd4096);
      drain();

      program_all('1, 32'hFFFF_FFFF, 16'hFFFF, 9'd1, 13'h1FFF, 4'hF);
      run_random(250, 40, 13'h1FFF);
      drain();

      // zero settings: depth 0 refuses every new request
      program_all('0, 32'd0, 16'd0, 9'd0, 13'd0, 4'd0);
      run_random(120, 30, 13'd64);
      drain();

      program_all(ADDR_W'(rand64()), $urandom, 16'($urandom), 9'd256,
                  13'($urandom_range(1, 4096)), 4'd8);
      run_random(400, 40, 13'd4096);
      drain();

      program_all(48'($urandom_range(0, 4096)), $urandom, 16'($urandom_range(0, 1024)),
                  9'd7, 13'($urandom_range(1, 256)), 4'($urandom_range(1, 8)));
      run_random(350, 45, 13'd2048);
      drain();

      // closing phase: narrow stride, no idling on either side
      no_idle = 1;
      program_all(48'h40, 32'd3, 16'd384, 9'h1FF, 13'd1, 4'd3);
      run_random(300, 45, 13'd512);
      drain();

      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
